>>> hdl/dgcr_pkg.sv
// Package: widths, status codes, result type and GCR frame decode for the reply decoder.
`timescale 1ns / 1ps
package dgcr_pkg;

    localparam int ReplyBits  = 21;
    localparam int CntW       = 5;
    localparam int DurW       = 15;
    localparam int PeriodW    = 12;
    localparam int DividendW  = 16;
    localparam int RawW       = 12;
    localparam int PeriodUsW  = 16;

    localparam logic [PeriodW-1:0] PeriodReset = 12'd53;

    localparam logic [1:0] StatusOk       = 2'd0;
    localparam logic [1:0] StatusBadStart = 2'd1;
    localparam logic [1:0] StatusBadGcr   = 2'd2;
    localparam logic [1:0] StatusBadCrc   = 2'd3;

    localparam logic [RawW-1:0] RawErpmZero = 12'hFFF;

    typedef struct packed {
        logic [1:0]           status;
        logic [RawW-1:0]      raw_value;
        logic                 is_erpm;
        logic [PeriodUsW-1:0] erpm_period;
        logic [3:0]           telem_type;
        logic [7:0]           telem_value;
    } t_result;

    // bit 4 marks a legal code, bits 3..0 the nibble
    function automatic logic [4:0] gcr_lookup(input logic [4:0] code);
        logic [4:0] e;
        unique case (code)
            5'h09:   e = 5'h19;
            5'h0A:   e = 5'h1A;
            5'h0B:   e = 5'h1B;
            5'h0D:   e = 5'h1D;
            5'h0E:   e = 5'h1E;
            5'h0F:   e = 5'h1F;
            5'h12:   e = 5'h12;
            5'h13:   e = 5'h13;
            5'h15:   e = 5'h15;
            5'h16:   e = 5'h16;
            5'h17:   e = 5'h17;
            5'h19:   e = 5'h10;
            5'h1A:   e = 5'h18;
            5'h1B:   e = 5'h11;
            5'h1D:   e = 5'h14;
            5'h1E:   e = 5'h1C;
            default: e = 5'h00;
        endcase
        return e;
    endfunction

    function automatic t_result decode_frame(input logic [ReplyBits-1:0] w);
        t_result          r;
        logic [ReplyBits-1:0] x;
        logic [15:0]      mapped;
        logic             legal;
        logic [4:0]       e;
        logic [3:0]       crc;
        logic [RawW-1:0]  raw;
        logic [3:0]       hi;
        r      = '0;
        x      = w ^ (w >> 1);
        mapped = '0;
        legal  = 1'b1;
        for (int i = 0; i < 4; i++) begin
            e = gcr_lookup(x[5*i +: 5]);
            legal = legal & e[4];
            mapped[4*i +: 4] = e[3:0];
        end
        crc = ~(mapped[7:4] ^ mapped[11:8] ^ mapped[15:12]);
        raw = mapped[15:4];
        hi  = raw[11:8];
        if (!legal) begin
            r.status = StatusBadGcr;
        end else if (crc != mapped[3:0]) begin
            r.status = StatusBadCrc;
        end else begin
            r.status    = StatusOk;
            r.raw_value = raw;
            if (hi == 4'd0 || hi[0]) begin
                r.is_erpm = 1'b1;
                if (raw != RawErpmZero) begin
                    r.erpm_period = {7'd0, raw[8:0]} << raw[11:9];
                end
            end else begin
                r.telem_type  = hi;
                r.telem_value = raw[7:0];
            end
        end
        return r;
    endfunction

endpackage

>>> hdl/dgcr_if.sv
// Channel interfaces: symbol input, decoded reply output, bit period config write.
`timescale 1ns / 1ps
interface dgcr_in_if;
    logic        valid;
    logic        ready;
    logic        first_level;
    logic [14:0] first_duration;
    logic        second_level;
    logic [14:0] second_duration;
    logic        last_symbol;
    modport source (output valid, first_level, first_duration, second_level,
                    second_duration, last_symbol, input ready);
    modport sink   (input valid, first_level, first_duration, second_level,
                    second_duration, last_symbol, output ready);
endinterface

interface dgcr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [11:0] raw_value;
    logic        is_erpm;
    logic [15:0] erpm_period;
    logic [3:0]  telem_type;
    logic [7:0]  telem_value;
    modport source (output valid, status, raw_value, is_erpm, erpm_period,
                    telem_type, telem_value, input ready);
    modport sink   (input valid, status, raw_value, is_erpm, erpm_period,
                    telem_type, telem_value, output ready);
endinterface

interface dgcr_cfg_if;
    logic        valid;
    logic        ready;
    logic [11:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> hdl/dshot_gcr_reply_decoder.sv
// Top level: bidirectional DShot GCR telemetry reply decoder.
//
// Usage:
//   i_in takes one captured line symbol per word (two level/duration phases
//   and a last_symbol flag). Each phase adds round(duration / bit period)
//   bits, at least one, to a 21-bit shift register; a reply ends at 21 bits,
//   at a zero duration or at the last symbol, and is then padded with ones,
//   unscrambled, GCR decoded and CRC checked.
//   o_out gives one word per finished reply (status, payload, eRPM or
//   extended telemetry fields). i_cfg writes the bit period (reset 53).
// Sequence:
//   Each decoded phase runs through one shared 16-step restoring divider:
//   the first phase goes through start, the divide steps, done and shift,
//   then the second phase, unless the reply is full or its duration is
//   zero, through divide, done and shift, so i_in.ready stays low for the
//   whole symbol. A symbol that ends the reply adds a decode and an emit
//   state before the word is valid; a bad start goes from start to emit.
//   i_in.ready is high only while the sequencer is idle.
// Reset clears the reply state and drops o_out.valid. If o_out stalls, the
// finished word waits in the output register and the sequencer holds in
// its emit state until the register frees up.
`timescale 1ns / 1ps
module dshot_gcr_reply_decoder
    import dgcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    dgcr_cfg_if.sink    i_cfg,
    dgcr_in_if.sink     i_in,
    dgcr_out_if.source  o_out
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_DECODE = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0]           r_state, n_state;
    logic [PeriodW-1:0]   r_period;
    logic [ReplyBits-1:0] r_shreg, n_shreg;
    logic [CntW-1:0]      r_cnt, n_cnt;
    logic                 r_finished, n_finished;
    logic                 r_expect, n_expect;
    logic                 r_phase, n_phase;
    logic                 r_bad, n_bad;
    logic                 r_ov;
    t_result              r_res;

    logic                 r_l0, r_l1, r_last;
    logic [DurW-1:0]      r_d0, r_d1;

    logic                 w_in_acc;
    logic                 w_load;
    logic                 w_div_start;
    logic                 w_div_sel1;
    logic                 w_div_done;
    logic [DividendW-1:0] w_quo;
    logic [DividendW-1:0] w_dividend;
    logic [PeriodW-1:0]   w_p;
    logic [CntW-1:0]      w_room;
    logic [CntW-1:0]      w_n;
    logic                 w_lvl;
    logic [ReplyBits-1:0] w_ones;
    logic [ReplyBits-1:0] w_shifted;
    t_result              w_res;
    t_result              w_bad_res;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PeriodReset;
        end else if (i_cfg.valid) begin
            r_period <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_l0   <= i_in.first_level;
            r_d0   <= i_in.first_duration;
            r_l1   <= i_in.second_level;
            r_d1   <= i_in.second_duration;
            r_last <= i_in.last_symbol;
        end
    end

    // rounding divide: (dur + p/2) / p, a zero period counts as one
    assign w_p        = (r_period == '0) ? PeriodW'(1) : r_period;
    assign w_dividend = DividendW'(w_div_sel1 ? r_d1 : r_d0) + DividendW'(w_p[PeriodW-1:1]);

    dgcr_div #(
        .DdW  (DividendW),
        .DivW (PeriodW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_p),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // shared bit inserter: phase bits in S_SHIFT, one-padding in S_DECODE
    assign w_room = CntW'(ReplyBits) - r_cnt;
    always_comb begin
        if (r_state == S_DECODE) begin
            w_n   = w_room;
            w_lvl = 1'b1;
        end else begin
            w_lvl = r_phase ? r_l1 : r_l0;
            if (w_quo == '0) begin
                w_n = CntW'(1);
            end else if (w_quo > DividendW'(w_room)) begin
                w_n = w_room;
            end else begin
                w_n = w_quo[CntW-1:0];
            end
        end
    end
    assign w_ones    = ReplyBits'((22'd1 << w_n) - 22'd1);
    assign w_shifted = (r_shreg << w_n) | (w_lvl ? w_ones : '0);

    assign w_res  = decode_frame(r_shreg);
    assign w_load = (r_state == S_EMIT) && (!r_ov || o_out.ready);

    always_comb begin
        w_bad_res        = '0;
        w_bad_res.status = StatusBadStart;
    end

    always_comb begin
        n_state     = r_state;
        n_shreg     = r_shreg;
        n_cnt       = r_cnt;
        n_finished  = r_finished;
        n_expect    = r_expect;
        n_phase     = r_phase;
        n_bad       = r_bad;
        w_div_start = 1'b0;
        w_div_sel1  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_phase = 1'b0;
                n_bad   = 1'b0;
                if (r_finished) begin
                    if (r_last) begin
                        n_shreg    = '0;
                        n_cnt      = '0;
                        n_finished = 1'b0;
                        n_expect   = 1'b1;
                    end
                    n_state = S_IDLE;
                end else begin
                    n_expect = 1'b0;
                    if (r_expect && (r_d0 == '0 || r_l0)) begin
                        n_bad   = 1'b1;
                        n_state = S_EMIT;
                    end else if (r_d0 == '0) begin
                        n_state = S_DECODE;
                    end else begin
                        w_div_start = 1'b1;
                        n_state     = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                n_shreg = w_shifted;
                n_cnt   = r_cnt + w_n;
                if (r_cnt + w_n == CntW'(ReplyBits)) begin
                    n_state = S_DECODE;
                end else if (!r_phase) begin
                    n_phase = 1'b1;
                    if (r_d1 == '0) begin
                        n_state = S_DECODE;
                    end else begin
                        w_div_start = 1'b1;
                        w_div_sel1  = 1'b1;
                        n_state     = S_DIV;
                    end
                end else if (r_last) begin
                    n_state = S_DECODE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DECODE: begin
                n_shreg = w_shifted;
                n_cnt   = CntW'(ReplyBits);
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_load) begin
                    n_finished = 1'b1;
                    if (r_last) begin
                        n_shreg    = '0;
                        n_cnt      = '0;
                        n_finished = 1'b0;
                        n_expect   = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_shreg    <= '0;
            r_cnt      <= '0;
            r_finished <= 1'b0;
            r_expect   <= 1'b1;
            r_phase    <= 1'b0;
            r_bad      <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_shreg    <= n_shreg;
            r_cnt      <= n_cnt;
            r_finished <= n_finished;
            r_expect   <= n_expect;
            r_phase    <= n_phase;
            r_bad      <= n_bad;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= r_bad ? w_bad_res : w_res;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.status      = r_res.status;
    assign o_out.raw_value   = r_res.raw_value;
    assign o_out.is_erpm     = r_res.is_erpm;
    assign o_out.erpm_period = r_res.erpm_period;
    assign o_out.telem_type  = r_res.telem_type;
    assign o_out.telem_value = r_res.telem_value;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(ReplyBits))
        else $error("bit count beyond reply length");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside divide state");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_out.valid)
        else $error("loaded word not presented");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != StatusOk) |->
            (o_out.raw_value == '0 && !o_out.is_erpm && o_out.telem_type == '0))
        else $error("error word carries payload");

    a_erpm_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_erpm) |->
            (o_out.telem_type == '0 && o_out.telem_value == '0))
        else $error("eRPM word carries telemetry fields");

endmodule

>>> hdl/dgcr_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module dgcr_div
    import dgcr_pkg::*;
#(
    parameter int DdW  = DividendW,
    parameter int DivW = PeriodW
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [DdW-1:0]  i_dividend,
    input  logic [DivW-1:0] i_divisor,
    output logic            o_done,
    output logic [DdW-1:0]  o_quotient
);

    localparam int StepW = $clog2(DdW + 1);

    logic             r_busy;
    logic             r_done;
    logic [StepW-1:0] r_step;
    logic [DivW:0]    r_rem;
    logic [DdW-1:0]   r_quo;
    logic [DivW-1:0]  r_div;

    logic [DivW:0]    w_trial;
    logic [DivW+1:0]  w_diff;

    assign w_trial = {r_rem[DivW-1:0], r_quo[DdW-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= StepW'(DdW);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == StepW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[DivW+1]) begin
                r_rem <= w_diff[DivW:0];
                r_quo <= {r_quo[DdW-2:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_quo <= {r_quo[DdW-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> tb/dshot_gcr_reply_decoder_test.sv
// Testbench for the GCR reply decoder: symbol stimulus, a behavioral decoder and word checking.
`timescale 1ns / 1ps
module dshot_gcr_reply_decoder_test
    import dgcr_pkg::*;
();

    localparam int CycleLimit   = 1_000_000;
    localparam int SettleCycles = 100;
    localparam int LongHold     = 3000;
    localparam int MaxTicks     = 32767;
    localparam int DirRows      = 17;

    typedef struct packed {
        logic             first_level;
        logic [DurW-1:0]  first_duration;
        logic             second_level;
        logic [DurW-1:0]  second_duration;
        logic             last_symbol;
    } t_symbol;

    typedef enum logic [1:0] {RowSymbol, RowFrame, RowBadCrc} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        t_symbol          sym;
        logic [RawW-1:0]  payload;
        logic             typed;
        logic [1:0]       status;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dgcr_cfg_if cfg_ch ();
    dgcr_in_if  sym_ch ();
    dgcr_out_if word_ch ();

    dshot_gcr_reply_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (sym_ch),
        .o_out   (word_ch)
    );

    always #5 i_clk = ~i_clk;

    // behavioral decoder state
    logic [ReplyBits-1:0] line_bits;
    int                   bits_taken;
    bit                   reply_done;
    bit                   at_first;
    logic [PeriodW-1:0]   bit_period;

    t_result pending_words[$];
    t_symbol reply_syms[$];
    t_row    directed [DirRows];
    t_row    row;
    t_result got_word, want_word;

    int errors        = 0;
    int cycles        = 0;
    int symbols_sent  = 0;
    int src_idle_pct  = 0;
    int snk_idle_pct  = 0;
    int hold_request  = 0;
    int hold_left     = 0;

    function automatic logic [4:0] gcr_encode(logic [3:0] nib);
        case (nib)
            4'h0: return 5'h19;
            4'h1: return 5'h1B;
            4'h2: return 5'h12;
            4'h3: return 5'h13;
            4'h4: return 5'h1D;
            4'h5: return 5'h15;
            4'h6: return 5'h16;
            4'h7: return 5'h17;
            4'h8: return 5'h1A;
            4'h9: return 5'h09;
            4'hA: return 5'h0A;
            4'hB: return 5'h0B;
            4'hC: return 5'h1E;
            4'hD: return 5'h0D;
            4'hE: return 5'h0E;
            default: return 5'h0F;
        endcase
    endfunction

    // reverse lookup through the encode map; returns 0 for an illegal code
    function automatic bit gcr_decode(logic [4:0] code, output logic [3:0] nib);
        nib = '0;
        for (int n = 0; n < 16; n++) begin
            if (gcr_encode(n[3:0]) == code) begin
                nib = n[3:0];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void restart_reply();
        line_bits  = '0;
        bits_taken = 0;
        reply_done = 1'b0;
        at_first   = 1'b1;
    endfunction

    function automatic void push_bits(int n, logic lvl);
        if (n > ReplyBits - bits_taken)
            n = ReplyBits - bits_taken;
        for (int i = 0; i < n; i++)
            line_bits = {line_bits[ReplyBits-2:0], lvl};
        bits_taken += n;
    endfunction

    function automatic bit take_phase(logic lvl, logic [DurW-1:0] dur);
        int p;
        int n;
        if (dur == 0)
            return 1'b1;
        p = (bit_period == 0) ? 1 : int'(bit_period);
        n = (int'(dur) + p / 2) / p;
        if (n == 0)
            n = 1;
        push_bits(n, lvl);
        return bits_taken >= ReplyBits;
    endfunction

    function automatic t_result decode_reply();
        t_result              r;
        logic [ReplyBits-1:0] x;
        logic [15:0]          nibbles;
        logic [3:0]           nib;
        logic [3:0]           crc;
        logic [RawW-1:0]      raw;
        logic [3:0]           hi;
        logic [PeriodUsW-1:0] mant;
        bit                   legal;
        r = '0;
        push_bits(ReplyBits, 1'b1);
        x = line_bits ^ (line_bits >> 1);
        nibbles = '0;
        legal = 1'b1;
        for (int g = 0; g < 4; g++) begin
            if (!gcr_decode(x[5*g +: 5], nib))
                legal = 1'b0;
            nibbles[4*g +: 4] = nib;
        end
        if (!legal) begin
            r.status = StatusBadGcr;
            return r;
        end
        crc = ~(nibbles[7:4] ^ nibbles[11:8] ^ nibbles[15:12]);
        if (crc != nibbles[3:0]) begin
            r.status = StatusBadCrc;
            return r;
        end
        raw = nibbles[15:4];
        hi  = raw[11:8];
        r.status    = StatusOk;
        r.raw_value = raw;
        if (hi == 4'd0 || hi[0]) begin
            r.is_erpm = 1'b1;
            if (raw != RawErpmZero) begin
                mant = {7'd0, raw[8:0]};
                r.erpm_period = mant << raw[11:9];
            end
        end else begin
            r.telem_type  = hi;
            r.telem_value = raw[7:0];
        end
        return r;
    endfunction

    // one accepted symbol; returns 1 when it finishes a reply
    function automatic bit decode_symbol(t_symbol s, output t_result r);
        bit done;
        bit has;
        done = 1'b0;
        has  = 1'b0;
        r    = '0;
        if (reply_done) begin
            if (s.last_symbol)
                restart_reply();
            return 1'b0;
        end
        if (at_first) begin
            at_first = 1'b0;
            if (s.first_duration == 0 || s.first_level) begin
                r.status = StatusBadStart;
                has  = 1'b1;
                done = 1'b1;
            end
        end
        if (!done) begin
            done = take_phase(s.first_level, s.first_duration);
            if (!done)
                done = take_phase(s.second_level, s.second_duration);
        end
        if (s.last_symbol)
            done = 1'b1;
        if (done && !has) begin
            r   = decode_reply();
            has = 1'b1;
        end
        if (done)
            reply_done = 1'b1;
        if (s.last_symbol)
            restart_reply();
        return has;
    endfunction

    function automatic logic [DurW-1:0] phase_ticks(int n, int p);
        int d;
        d = n * p - p / 2 + int'($urandom_range(p - 1));
        if (d < 1)
            d = 1;
        if (d > MaxTicks)
            d = MaxTicks;
        return d[DurW-1:0];
    endfunction

    function automatic logic [DurW-1:0] noise_ticks(int p);
        int lim;
        lim = (p * 4 < MaxTicks) ? p * 4 : MaxTicks;
        case ($urandom_range(7))
            0:       return '0;
            1, 2, 3: return DurW'($urandom_range(MaxTicks));
            default: return DurW'($urandom_range(lim));
        endcase
    endfunction

    function automatic t_symbol random_symbol(int p);
        t_symbol     s;
        logic [31:0] rnd;
        rnd = $urandom;
        s.first_level     = rnd[0];
        s.second_level    = rnd[1];
        s.last_symbol     = (rnd[4:2] == 3'd0);
        s.first_duration  = noise_ticks(p);
        s.second_duration = noise_ticks(p);
        return s;
    endfunction

    function automatic logic [RawW-1:0] pick_payload();
        logic [31:0] rnd;
        rnd = $urandom;
        case ($urandom_range(9))
            0:       return RawErpmZero;
            1:       return {rnd[14:12], 1'b0, rnd[7:0]};
            default: return rnd[RawW-1:0];
        endcase
    endfunction

    // Encodes one payload into line symbols at the current bit period.
    // shaped: random tail trimming, end markers and trailing junk.
    function automatic void build_reply(logic [RawW-1:0] payload, bit bad_crc, int flips,
                                        bit shaped);
        logic [15:0]          word;
        logic [3:0]           crc;
        logic [ReplyBits-1:0] x;
        logic [ReplyBits-1:0] w;
        int                   run_len[$];
        bit                   run_lvl[$];
        int                   p;
        int                   k;
        int                   idx;
        int                   tail;
        t_symbol              s;
        reply_syms.delete();
        p = (bit_period == 0) ? 1 : int'(bit_period);
        crc = ~(payload[3:0] ^ payload[7:4] ^ payload[11:8]);
        if (bad_crc)
            crc = crc ^ 4'h1;
        word = {payload, crc};
        x = {1'b0, gcr_encode(word[15:12]), gcr_encode(word[11:8]),
             gcr_encode(word[7:4]), gcr_encode(word[3:0])};
        for (int i = 0; i < flips; i++) begin
            idx = $urandom_range(19);
            x[idx] = ~x[idx];
        end
        // scramble: inverse of w ^ (w >> 1)
        w[ReplyBits-1] = x[ReplyBits-1];
        for (int i = ReplyBits - 2; i >= 0; i--)
            w[i] = x[i] ^ w[i+1];
        run_lvl.push_back(w[ReplyBits-1]);
        run_len.push_back(1);
        for (int i = ReplyBits - 2; i >= 0; i--) begin
            k = run_len.size() - 1;
            if (w[i] == run_lvl[k])
                run_len[k] = run_len[k] + 1;
            else begin
                run_lvl.push_back(w[i]);
                run_len.push_back(1);
            end
        end
        // trailing ones may be left to the padding
        if (shaped && run_len.size() > 1 && run_lvl[run_lvl.size()-1] && $urandom_range(1)) begin
            void'(run_lvl.pop_back());
            void'(run_len.pop_back());
        end
        k = 0;
        while (k < run_len.size()) begin
            s.first_level    = run_lvl[k];
            s.first_duration = phase_ticks(run_len[k], p);
            if (k + 1 < run_len.size()) begin
                s.second_level    = run_lvl[k+1];
                s.second_duration = phase_ticks(run_len[k+1], p);
            end else if (shaped && $urandom_range(1)) begin
                s.second_level    = 1'b1;
                s.second_duration = phase_ticks(1, p);
            end else begin
                s.second_level    = ~run_lvl[k];
                s.second_duration = '0;
            end
            s.last_symbol = 1'b0;
            reply_syms.push_back(s);
            k += 2;
        end
        tail = shaped ? $urandom_range(19) : 5;
        if (tail >= 1 && tail <= 4) begin
            for (int j = 0; j < tail; j++) begin
                s = random_symbol(p);
                s.last_symbol = 1'b0;
                reply_syms.push_back(s);
            end
        end
        // no last flag at all: the next reply is swallowed until its own last symbol
        if (tail != 0) begin
            s = reply_syms.pop_back();
            s.last_symbol = 1'b1;
            reply_syms.push_back(s);
        end
    endfunction

    task automatic send_symbol(t_symbol s, logic typed, logic [1:0] typed_status);
        t_result r;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            sym_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        sym_ch.valid           <= 1'b1;
        sym_ch.first_level     <= s.first_level;
        sym_ch.first_duration  <= s.first_duration;
        sym_ch.second_level    <= s.second_level;
        sym_ch.second_duration <= s.second_duration;
        sym_ch.last_symbol     <= s.last_symbol;
        @(posedge i_clk);
        while (!sym_ch.ready)
            @(posedge i_clk);
        if (decode_symbol(s, r)) begin
            if (typed) begin
                r = '0;
                r.status = typed_status;
            end
            pending_words.push_back(r);
        end
        symbols_sent++;
    endtask

    task automatic send_reply();
        foreach (reply_syms[j])
            send_symbol(reply_syms[j], 1'b0, StatusOk);
    endtask

    // drop valid, drain every pending word, then let the sequencer settle
    task automatic wait_idle();
        @(negedge i_clk);
        sym_ch.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_period(logic [PeriodW-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        bit_period = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(logic [PeriodW-1:0] period, int src, int snk, int quota,
                             int hold_cycles);
        int target;
        int pick;
        int burst;
        t_symbol s;
        wait_idle();
        write_period(period);
        src_idle_pct = src;
        snk_idle_pct = snk;
        hold_request = hold_cycles;
        target = symbols_sent + quota;
        while (symbols_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 75)
                build_reply(pick_payload(), 1'b0, 0, 1'b1);
            else if (pick < 82)
                build_reply(pick_payload(), 1'b1, 0, 1'b1);
            else if (pick < 90)
                build_reply(pick_payload(), 1'b0, $urandom_range(2, 1), 1'b1);
            else begin
                reply_syms.delete();
                burst = $urandom_range(4, 1);
                for (int j = 0; j < burst; j++)
                    reply_syms.push_back(random_symbol((bit_period == 0) ? 1 : bit_period));
                if ($urandom_range(9) != 0) begin
                    s = reply_syms.pop_back();
                    s.last_symbol = 1'b1;
                    reply_syms.push_back(s);
                end
            end
            send_reply();
        end
    endtask

    // receiver: random stalls plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            word_ch.ready <= 1'b0;
        end else begin
            word_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && word_ch.valid && word_ch.ready) begin
            got_word = {word_ch.status, word_ch.raw_value, word_ch.is_erpm,
                        word_ch.erpm_period, word_ch.telem_type, word_ch.telem_value};
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got_word);
                errors++;
            end else begin
                want_word = pending_words.pop_front();
                if (got_word.status != want_word.status)
                    $display("%0t: status expected %0d, got %0d", $time,
                             want_word.status, got_word.status);
                if (got_word.raw_value != want_word.raw_value)
                    $display("%0t: raw_value expected %h, got %h", $time,
                             want_word.raw_value, got_word.raw_value);
                if (got_word.is_erpm != want_word.is_erpm)
                    $display("%0t: is_erpm expected %0d, got %0d", $time,
                             want_word.is_erpm, got_word.is_erpm);
                if (got_word.erpm_period != want_word.erpm_period)
                    $display("%0t: erpm_period expected %0d, got %0d", $time,
                             want_word.erpm_period, got_word.erpm_period);
                if (got_word.telem_type != want_word.telem_type)
                    $display("%0t: telem_type expected %h, got %h", $time,
                             want_word.telem_type, got_word.telem_type);
                if (got_word.telem_value != want_word.telem_value)
                    $display("%0t: telem_value expected %h, got %h", $time,
                             want_word.telem_value, got_word.telem_value);
                if (got_word != want_word)
                    errors++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        sym_ch.valid           = 1'b0;
        sym_ch.first_level     = 1'b0;
        sym_ch.first_duration  = '0;
        sym_ch.second_level    = 1'b0;
        sym_ch.second_duration = '0;
        sym_ch.last_symbol     = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.data            = '0;
        i_rst_n                = 1'b0;
        restart_reply();
        bit_period   = PeriodReset;
        src_idle_pct = 14;
        snk_idle_pct = 81;

        // bit period 53 after reset
        directed = '{
            // bad start: level high, then ignored up to the last symbol
            '{RowSymbol, '{1'b1, 15'd53, 1'b0, 15'd53, 1'b0}, 12'h000, 1'b1, StatusBadStart},
            '{RowSymbol, '{1'b0, 15'd53, 1'b1, 15'd53, 1'b1}, 12'h000, 1'b0, StatusOk},
            // bad start: zero duration
            '{RowSymbol, '{1'b0, 15'd0, 1'b0, 15'd0, 1'b1}, 12'h000, 1'b1, StatusBadStart},
            // long phase clipped to 21 zeros
            '{RowSymbol, '{1'b0, 15'd32767, 1'b1, 15'd32767, 1'b1}, 12'h000, 1'b1,
              StatusBadGcr},
            // one zero bit, end marker, ones padding
            '{RowSymbol, '{1'b0, 15'd53, 1'b1, 15'd0, 1'b1}, 12'h000, 1'b1, StatusBadGcr},
            // short phases round up to one bit each
            '{RowSymbol, '{1'b0, 15'd1, 1'b1, 15'd1, 1'b0}, 12'h000, 1'b0, StatusOk},
            '{RowSymbol, '{1'b1, 15'd32767, 1'b0, 15'd32767, 1'b1}, 12'h000, 1'b1,
              StatusBadGcr},
            '{RowFrame, '0, 12'h000, 1'b0, StatusOk},
            '{RowFrame, '0, 12'hFFF, 1'b0, StatusOk},
            '{RowFrame, '0, 12'hFFE, 1'b0, StatusOk},
            '{RowFrame, '0, 12'h2AB, 1'b0, StatusOk},
            '{RowFrame, '0, 12'hEFF, 1'b0, StatusOk},
            '{RowFrame, '0, 12'h400, 1'b0, StatusOk},
            '{RowFrame, '0, 12'h1FF, 1'b0, StatusOk},
            '{RowBadCrc, '0, 12'h123, 1'b1, StatusBadCrc},
            '{RowSymbol, '{1'b0, 15'd106, 1'b1, 15'd53, 1'b0}, 12'h000, 1'b0, StatusOk},
            '{RowSymbol, '{1'b0, 15'd53, 1'b1, 15'd53, 1'b1}, 12'h000, 1'b0, StatusOk}
        };

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            row = directed[i];
            if (row.kind == RowSymbol)
                send_symbol(row.sym, row.typed, row.status);
            else begin
                build_reply(row.payload, row.kind == RowBadCrc, 0, 1'b0);
                foreach (reply_syms[j])
                    send_symbol(reply_syms[j], row.typed, row.status);
            end
        end

        run_phase(PeriodReset, 14, 81, 300, LongHold);
        run_phase(12'd1, 14, 81, 250, 0);
        run_phase(12'd4095, 81, 14, 250, 0);
        run_phase(12'd0, 81, 14, 200, 0);
        run_phase(12'd8, 0, 0, 300, 0);
        run_phase(PeriodW'($urandom_range(4095, 1)), 0, 0, 330, 0);
        wait_idle();

        if (errors == 0 && pending_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
hdl/dgcr_pkg.sv
hdl/dgcr_if.sv
hdl/dgcr_div.sv
hdl/dshot_gcr_reply_decoder.sv
tb/dshot_gcr_reply_decoder_test.sv
